// File: hw/rtl/sbt_pkg.sv
// sbt_pkg: shared types, character codes, token kinds and keyword tables
// for the source byte tokenizer. No dependencies.
`timescale 1ns / 1ps

package sbt_pkg;

  // default widths of the internal counters
  localparam int OFFSET_BITS_DEF = 32;
  localparam int COUNT_BITS_DEF  = 16;

  // bundles held between front and back
  localparam int QUEUE_DEPTH = 4;

  // configuration register reset values and register indexes
  localparam logic [15:0] FIRST_LINE_RST = 16'd1;
  localparam logic [4:0]  TAB_WIDTH_RST  = 5'd4;
  localparam int          APB_ADDR_BITS  = 3;
  localparam logic        REG_FIRST_LINE = 1'b0;
  localparam logic        REG_TAB_WIDTH  = 1'b1;

  // character codes
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_ASSIGN = 8'h3D;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  // keywords: int, return, string
  localparam logic [2:0] KW_LEN [3] = '{3'd3, 3'd6, 3'd6};
  localparam logic [7:0] KW_TEXT [3][6] = '{
    '{8'h69, 8'h6E, 8'h74, 8'h00, 8'h00, 8'h00},
    '{8'h72, 8'h65, 8'h74, 8'h75, 8'h72, 8'h6E},
    '{8'h73, 8'h74, 8'h72, 8'h69, 8'h6E, 8'h67}
  };

  typedef enum logic [4:0] {
    KIND_NEWLINE = 5'd0,
    KIND_ASSIGN  = 5'd1,
    KIND_PLUS    = 5'd2,
    KIND_STAR    = 5'd3,
    KIND_SLASH   = 5'd4,
    KIND_SEMI    = 5'd5,
    KIND_LPAREN  = 5'd6,
    KIND_RPAREN  = 5'd7,
    KIND_LBRACE  = 5'd8,
    KIND_RBRACE  = 5'd9,
    KIND_COMMA   = 5'd10,
    KIND_NUMBER  = 5'd11,
    KIND_STRING  = 5'd12,
    KIND_KW_INT  = 5'd13,
    KIND_KW_RET  = 5'd14,
    KIND_KW_STR  = 5'd15,
    KIND_IDENT   = 5'd16,
    KIND_ERROR   = 5'd17,
    KIND_END     = 5'd18
  } kind_t;

  // one token as it leaves the block
  typedef struct packed {
    kind_t       kind;
    logic [15:0] line;
    logic [15:0] column;
    logic [31:0] offset;
    logic [15:0] length;
  } token_t;

  // token slots of a bundle, in output order
  localparam int SLOT_WORD  = 0;
  localparam int SLOT_DELIM = 1;
  localparam int SLOT_END   = 2;

  // all tokens caused by one input item
  typedef struct packed {
    logic [2:0]       present;
    token_t [2:0]     tok;
  } bundle_t;

  // configuration seen by the front
  typedef struct packed {
    logic [15:0] first_line;
    logic [4:0]  tab_width;
    logic        line_load;
    logic [15:0] line_load_value;
  } cfg_t;

  function automatic logic is_digit(logic [7:0] b);
    return (b >= CH_ZERO) && (b <= CH_NINE);
  endfunction

endpackage

// File: hw/rtl/sbt_if.sv
// sbt_if: valid/ready channels for source bytes in and tokens out.
// Depends on nothing.
`timescale 1ns / 1ps

interface sbt_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] source_byte;
  logic       end_of_source;

  modport source (output valid, source_byte, end_of_source, input ready);
  modport sink   (input valid, source_byte, end_of_source, output ready);
endinterface

interface sbt_token_if;
  logic        valid;
  logic        ready;
  logic [4:0]  token_kind;
  logic [15:0] token_line;
  logic [15:0] token_column;
  logic [31:0] token_offset;
  logic [15:0] token_length;
  logic        last_in_run;

  modport source (output valid, token_kind, token_line, token_column, token_offset,
                  token_length, last_in_run, input ready);
  modport sink   (input valid, token_kind, token_line, token_column, token_offset,
                  token_length, last_in_run, output ready);
endinterface

// File: hw/rtl/sbt_front.sv
// sbt_front: takes one source byte per cycle while the queue is not full, tracks
// counters and the pending word, and builds the bundle of tokens the byte causes.
// Depends on sbt_pkg and sbt_if.
`timescale 1ns / 1ps

module sbt_front #(
  parameter int OFFSET_BITS = sbt_pkg::OFFSET_BITS_DEF,
  parameter int COUNT_BITS  = sbt_pkg::COUNT_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  sbt_pkg::cfg_t     cfg,
  sbt_byte_if.sink          byte_in,
  input  logic              queue_full,
  output logic              push,
  output sbt_pkg::bundle_t  push_data
);

  localparam logic [COUNT_BITS-1:0]  COUNT_MAX  = '1;
  localparam logic [OFFSET_BITS-1:0] OFFSET_MAX = '1;

  // counters and pending word
  logic [COUNT_BITS-1:0]  line_count;
  logic [COUNT_BITS-1:0]  column_count;
  logic [OFFSET_BITS-1:0] byte_position;
  logic                   inside_word;
  logic [OFFSET_BITS-1:0] word_start;
  logic [COUNT_BITS-1:0]  word_length;
  logic [1:0]             word_flags;   // bit0 all digits, bit1 last byte is quote
  logic [2:0]             kw_cand;
  logic [7:0]             word_first;

  logic [7:0]             b;
  logic                   eos;
  logic                   accept;
  logic                   dtok;
  sbt_pkg::kind_t         dkind;
  logic                   delim;

  logic [COUNT_BITS-1:0]  base_len;
  logic [1:0]             base_flags;
  logic [2:0]             base_cand;
  logic [7:0]             base_first;
  logic [OFFSET_BITS-1:0] base_start;
  logic [COUNT_BITS-1:0]  app_len;
  logic [1:0]             app_flags;
  logic [2:0]             app_cand;

  logic                   flush_v;
  logic [COUNT_BITS-1:0]  fw_len;
  logic [1:0]             fw_flags;
  logic [2:0]             fw_cand;
  logic [7:0]             fw_first;
  logic [OFFSET_BITS-1:0] fw_start;
  sbt_pkg::kind_t         fkind;

  logic [COUNT_BITS-1:0]  col_f;
  logic [COUNT_BITS-1:0]  col_d;
  logic [COUNT_BITS-1:0]  line_d;
  logic [OFFSET_BITS-1:0] pos_next;

  function automatic logic [COUNT_BITS-1:0] cnt_add(logic [COUNT_BITS-1:0] a,
                                                    logic [COUNT_BITS-1:0] d);
    logic [COUNT_BITS:0] s;
    s = {1'b0, a} + {1'b0, d};
    return s[COUNT_BITS] ? COUNT_MAX : s[COUNT_BITS-1:0];
  endfunction

  function automatic logic [OFFSET_BITS-1:0] pos_inc(logic [OFFSET_BITS-1:0] a);
    return (a == OFFSET_MAX) ? OFFSET_MAX : a + OFFSET_BITS'(1);
  endfunction

  // first line clipped to the counter range
  function automatic logic [COUNT_BITS-1:0] line_start(logic [15:0] v);
    return (32'(v) > 32'(COUNT_MAX)) ? COUNT_MAX : COUNT_BITS'(v);
  endfunction

  function automatic sbt_pkg::kind_t word_kind(logic [COUNT_BITS-1:0] len,
                                               logic [1:0] flags,
                                               logic [2:0] cand,
                                               logic [7:0] first);
    sbt_pkg::kind_t k;
    if (len == COUNT_BITS'(1) && first == sbt_pkg::CH_STAR) begin
      k = sbt_pkg::KIND_STAR;
    end else if (len == COUNT_BITS'(1) && first == sbt_pkg::CH_SLASH) begin
      k = sbt_pkg::KIND_SLASH;
    end else if (len == COUNT_BITS'(1) && first == sbt_pkg::CH_COMMA) begin
      k = sbt_pkg::KIND_COMMA;
    end else if (flags[0]) begin
      k = sbt_pkg::KIND_NUMBER;
    end else if (first == sbt_pkg::CH_QUOTE && flags[1]) begin
      k = sbt_pkg::KIND_STRING;
    end else if (!sbt_pkg::is_digit(first)) begin
      if (cand[0] && len == COUNT_BITS'(sbt_pkg::KW_LEN[0])) begin
        k = sbt_pkg::KIND_KW_INT;
      end else if (cand[1] && len == COUNT_BITS'(sbt_pkg::KW_LEN[1])) begin
        k = sbt_pkg::KIND_KW_RET;
      end else if (cand[2] && len == COUNT_BITS'(sbt_pkg::KW_LEN[2])) begin
        k = sbt_pkg::KIND_KW_STR;
      end else begin
        k = sbt_pkg::KIND_IDENT;
      end
    end else begin
      k = sbt_pkg::KIND_ERROR;
    end
    return k;
  endfunction

  assign b              = byte_in.source_byte;
  assign eos            = byte_in.end_of_source;
  assign byte_in.ready  = !queue_full;
  assign accept         = byte_in.valid && byte_in.ready;

  // single-character tokens
  always_comb begin
    dtok  = 1'b1;
    dkind = sbt_pkg::KIND_NEWLINE;
    unique case (b)
      sbt_pkg::CH_NL:     dkind = sbt_pkg::KIND_NEWLINE;
      sbt_pkg::CH_ASSIGN: dkind = sbt_pkg::KIND_ASSIGN;
      sbt_pkg::CH_PLUS:   dkind = sbt_pkg::KIND_PLUS;
      sbt_pkg::CH_SEMI:   dkind = sbt_pkg::KIND_SEMI;
      sbt_pkg::CH_LPAREN: dkind = sbt_pkg::KIND_LPAREN;
      sbt_pkg::CH_RPAREN: dkind = sbt_pkg::KIND_RPAREN;
      sbt_pkg::CH_LBRACE: dkind = sbt_pkg::KIND_LBRACE;
      sbt_pkg::CH_RBRACE: dkind = sbt_pkg::KIND_RBRACE;
      default:            dtok  = 1'b0;
    endcase
  end

  assign delim = dtok || (b == sbt_pkg::CH_SPACE) || (b == sbt_pkg::CH_TAB);

  // word after this byte is appended, either extending or opening one
  always_comb begin
    base_len   = inside_word ? word_length : '0;
    base_flags = inside_word ? word_flags  : 2'b01;
    base_cand  = inside_word ? kw_cand     : 3'b111;
    base_first = inside_word ? word_first  : b;
    base_start = inside_word ? word_start  : byte_position;

    app_cand[0] = base_cand[0] && (base_len < COUNT_BITS'(sbt_pkg::KW_LEN[0]))
                  && (sbt_pkg::KW_TEXT[0][base_len[2:0]] == b);
    app_cand[1] = base_cand[1] && (base_len < COUNT_BITS'(sbt_pkg::KW_LEN[1]))
                  && (sbt_pkg::KW_TEXT[1][base_len[2:0]] == b);
    app_cand[2] = base_cand[2] && (base_len < COUNT_BITS'(sbt_pkg::KW_LEN[2]))
                  && (sbt_pkg::KW_TEXT[2][base_len[2:0]] == b);
    app_flags[0] = base_flags[0] && sbt_pkg::is_digit(b);
    app_flags[1] = (b == sbt_pkg::CH_QUOTE);
    app_len      = cnt_add(base_len, COUNT_BITS'(1));
  end

  // at most one word finishes per byte: the old one at a delimiter,
  // or the current one at end of source
  always_comb begin
    flush_v  = delim ? inside_word : eos;
    fw_len   = delim ? word_length : app_len;
    fw_flags = delim ? word_flags  : app_flags;
    fw_cand  = delim ? kw_cand     : app_cand;
    fw_first = delim ? word_first  : base_first;
    fw_start = delim ? word_start  : base_start;
    fkind    = word_kind(fw_len, fw_flags, fw_cand, fw_first);
  end

  // column and line after the word and after the delimiter
  always_comb begin
    col_f  = (flush_v && fkind != sbt_pkg::KIND_ERROR) ?
             cnt_add(column_count, fw_len) : column_count;
    col_d  = col_f;
    line_d = line_count;
    if (b == sbt_pkg::CH_SPACE) begin
      col_d = cnt_add(col_f, COUNT_BITS'(1));
    end else if (b == sbt_pkg::CH_TAB) begin
      col_d = cnt_add(col_f, COUNT_BITS'(cfg.tab_width));
    end else if (dtok && dkind == sbt_pkg::KIND_NEWLINE) begin
      col_d  = '0;
      line_d = cnt_add(line_count, COUNT_BITS'(1));
    end else if (dtok) begin
      col_d = cnt_add(col_f, COUNT_BITS'(1));
    end
    pos_next = pos_inc(byte_position);
  end

  // bundle for the queue
  always_comb begin
    push_data.present = {eos, dtok, flush_v};

    push_data.tok[sbt_pkg::SLOT_WORD].kind   = fkind;
    push_data.tok[sbt_pkg::SLOT_WORD].line   = 16'(line_count);
    push_data.tok[sbt_pkg::SLOT_WORD].column = 16'(column_count);
    push_data.tok[sbt_pkg::SLOT_WORD].offset = 32'(fw_start);
    push_data.tok[sbt_pkg::SLOT_WORD].length = 16'(fw_len);

    push_data.tok[sbt_pkg::SLOT_DELIM].kind   = dkind;
    push_data.tok[sbt_pkg::SLOT_DELIM].line   = 16'(line_count);
    push_data.tok[sbt_pkg::SLOT_DELIM].column = 16'(col_f);
    push_data.tok[sbt_pkg::SLOT_DELIM].offset = 32'(byte_position);
    push_data.tok[sbt_pkg::SLOT_DELIM].length = 16'd1;

    push_data.tok[sbt_pkg::SLOT_END].kind   = sbt_pkg::KIND_END;
    push_data.tok[sbt_pkg::SLOT_END].line   = 16'(line_d);
    push_data.tok[sbt_pkg::SLOT_END].column = 16'(col_d);
    push_data.tok[sbt_pkg::SLOT_END].offset = 32'(pos_next);
    push_data.tok[sbt_pkg::SLOT_END].length = 16'd0;
  end

  assign push = accept && (push_data.present != 3'b000);

  // state update
  always_ff @(posedge clk) begin
    if (rst) begin
      line_count    <= line_start(sbt_pkg::FIRST_LINE_RST);
      column_count  <= '0;
      byte_position <= '0;
      inside_word   <= 1'b0;
      word_start    <= '0;
      word_length   <= '0;
      word_flags    <= '0;
      kw_cand       <= 3'b111;
      word_first    <= '0;
    end else if (accept) begin
      if (eos) begin
        line_count    <= line_start(cfg.first_line);
        column_count  <= '0;
        byte_position <= '0;
        inside_word   <= 1'b0;
        word_start    <= '0;
        word_length   <= '0;
        word_flags    <= '0;
        kw_cand       <= 3'b111;
        word_first    <= '0;
      end else begin
        line_count    <= line_d;
        column_count  <= col_d;
        byte_position <= pos_next;
        if (delim) begin
          inside_word <= 1'b0;
          word_start  <= '0;
          word_length <= '0;
          word_flags  <= '0;
          kw_cand     <= 3'b111;
          word_first  <= '0;
        end else begin
          inside_word <= 1'b1;
          word_start  <= base_start;
          word_length <= app_len;
          word_flags  <= app_flags;
          kw_cand     <= app_cand;
          word_first  <= base_first;
        end
      end
    end else if (cfg.line_load && byte_position == '0 && !inside_word) begin
      // new first line applies at once before the source starts
      line_count <= line_start(cfg.line_load_value);
    end
  end

endmodule

// File: hw/rtl/sbt_queue.sv
// sbt_queue: short queue of token bundles between front and back.
// Depends on sbt_pkg.
`timescale 1ns / 1ps

module sbt_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  sbt_pkg::bundle_t  push_data,
  output logic              full,
  input  logic              pop,
  output logic              head_valid,
  output sbt_pkg::bundle_t  head
);

  localparam int DEPTH    = sbt_pkg::QUEUE_DEPTH;
  localparam int PTR_BITS = $clog2(DEPTH);
  localparam int CNT_BITS = $clog2(DEPTH + 1);

  sbt_pkg::bundle_t      slots [DEPTH];
  logic [PTR_BITS-1:0]   wr_ptr;
  logic [PTR_BITS-1:0]   rd_ptr;
  logic [CNT_BITS-1:0]   count;
  logic                  do_push;
  logic                  do_pop;

  assign full       = (count == CNT_BITS'(DEPTH));
  assign head_valid = (count != '0);
  assign head       = slots[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr + PTR_BITS'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr + PTR_BITS'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_BITS'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_BITS'(1);
      end
    end
  end

  // bundle storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

// File: hw/rtl/sbt_back.sv
// sbt_back: walks the tokens of the head bundle in order and drives them
// through the output register. Depends on sbt_pkg and sbt_if.
`timescale 1ns / 1ps

module sbt_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              head_valid,
  input  sbt_pkg::bundle_t  head,
  output logic              pop,
  sbt_token_if.source       token_out
);

  logic [2:0]       done;
  logic [2:0]       rem;
  logic [1:0]       sel;
  logic [2:0]       sel_bit;
  logic             last;
  logic             adv;

  logic             out_valid;
  sbt_pkg::token_t  out_tok;
  logic             out_last;

  // next token of the head bundle
  always_comb begin
    rem = head.present & ~done;
    if (rem[0]) begin
      sel     = 2'd0;
      sel_bit = 3'b001;
    end else if (rem[1]) begin
      sel     = 2'd1;
      sel_bit = 3'b010;
    end else begin
      sel     = 2'd2;
      sel_bit = 3'b100;
    end
    last = ((rem & ~sel_bit) == 3'b000);
  end

  assign adv = head_valid && (!out_valid || token_out.ready);
  assign pop = adv && last;

  // output register and progress through the bundle
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      done      <= '0;
    end else begin
      if (adv) begin
        out_valid <= 1'b1;
      end else if (token_out.ready) begin
        out_valid <= 1'b0;
      end
      if (adv) begin
        done <= last ? 3'b000 : (done | sel_bit);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_tok  <= head.tok[sel];
      out_last <= last;
    end
  end

  assign token_out.valid        = out_valid;
  assign token_out.token_kind   = out_tok.kind;
  assign token_out.token_line   = out_tok.line;
  assign token_out.token_column = out_tok.column;
  assign token_out.token_offset = out_tok.offset;
  assign token_out.token_length = out_tok.length;
  assign token_out.last_in_run  = out_last;

endmodule

// File: hw/rtl/source_byte_tokenizer_unit.sv
// Source byte tokenizer, top level: configuration registers, front, queue, back.
// Tokens of an accepted byte pass through the queue and then the output register to token_out.
// Throughput: one byte per cycle while the queue has room; a byte with k tokens sends them
// out one after another, and byte_in stalls only when the four-bundle queue is full.
// Reset (rst, synchronous): first_line 1, tab_width 4, line counter 1, other counters and word cleared.
// Depends on sbt_pkg, sbt_if, sbt_front, sbt_queue, sbt_back.
`timescale 1ns / 1ps

module source_byte_tokenizer_unit #(
  parameter int OFFSET_BITS = sbt_pkg::OFFSET_BITS_DEF,
  parameter int COUNT_BITS  = sbt_pkg::COUNT_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  sbt_byte_if.sink                          byte_in,
  sbt_token_if.source                       token_out,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [sbt_pkg::APB_ADDR_BITS-1:0] paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);

  logic [15:0]       first_line;
  logic [4:0]        tab_width;
  logic              cfg_wr;
  logic              reg_sel;
  sbt_pkg::cfg_t     cfg;

  logic              push;
  sbt_pkg::bundle_t  push_data;
  logic              queue_full;
  logic              pop;
  logic              head_valid;
  sbt_pkg::bundle_t  head;

  // configuration registers
  assign pready  = 1'b1;
  assign reg_sel = paddr[2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      first_line <= sbt_pkg::FIRST_LINE_RST;
      tab_width  <= sbt_pkg::TAB_WIDTH_RST;
    end else if (cfg_wr) begin
      if (reg_sel == sbt_pkg::REG_FIRST_LINE) begin
        first_line <= pwdata[15:0];
      end else begin
        tab_width <= pwdata[4:0];
      end
    end
  end

  assign prdata = (reg_sel == sbt_pkg::REG_TAB_WIDTH) ? 32'(tab_width) : 32'(first_line);

  always_comb begin
    cfg.first_line      = first_line;
    cfg.tab_width       = tab_width;
    cfg.line_load       = cfg_wr && (reg_sel == sbt_pkg::REG_FIRST_LINE);
    cfg.line_load_value = pwdata[15:0];
  end

  sbt_front #(
    .OFFSET_BITS (OFFSET_BITS),
    .COUNT_BITS  (COUNT_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .byte_in    (byte_in),
    .queue_full (queue_full),
    .push       (push),
    .push_data  (push_data)
  );

  sbt_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (push_data),
    .full       (queue_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  sbt_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .token_out  (token_out)
  );

endmodule

// File: hw/rtl/sbt_checker.sv
// sbt_checker: port-level assertions for the tokenizer, bound to the top level.
// Depends on sbt_pkg and source_byte_tokenizer_unit.
`timescale 1ns / 1ps

module sbt_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [4:0]  token_kind,
  input  logic [15:0] token_length,
  input  logic        last_in_run
);

  // output register is empty right after reset
  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("token output valid right after reset");

  // a stalled token holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(token_kind) && $stable(token_length))
    else $error("stalled token changed");

  // end marker closes its run and has no text
  a_end_marker: assert property (@(posedge clk) disable iff (rst)
    out_valid && token_kind == sbt_pkg::KIND_END |-> last_in_run && token_length == 16'd0)
    else $error("end marker malformed");

  // single-character tokens and one-character symbols are one long
  a_single_char: assert property (@(posedge clk) disable iff (rst)
    out_valid && token_kind <= sbt_pkg::KIND_COMMA |-> token_length == 16'd1)
    else $error("single-character token with wrong length");

endmodule

bind source_byte_tokenizer_unit sbt_checker u_sbt_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (token_out.valid),
  .out_ready    (token_out.ready),
  .token_kind   (token_out.token_kind),
  .token_length (token_out.token_length),
  .last_in_run  (token_out.last_in_run)
);

// File: bench/testbench.sv
// testbench: self-checking bench for source_byte_tokenizer_unit, with a token predictor,
// directed and random byte streams, APB register writes with read-back, and flow control.
// Depends on sbt_pkg, sbt_if and the tokenizer RTL.
`timescale 1ns / 1ps

module testbench;

  localparam int QUIET_CYCLES = 8;
  localparam int LONG_HOLD    = 120;
  localparam int PHASE_ITEMS  = 36;

  // register settings and flow control per random phase
  localparam logic [15:0] PHASE_FIRST_LINE [4] = '{16'd0, 16'd65535, 16'd65534, 16'd300};
  localparam logic [4:0]  PHASE_TAB        [4] = '{5'd1, 5'd16, 5'd0, 5'd31};
  localparam int          PHASE_SEND_IDLE  [4] = '{0, 67, 0, 34};
  localparam int          PHASE_SINK_STALL [4] = '{0, 0, 67, 34};

  // one expected token plus its end-of-run flag
  typedef struct packed {
    sbt_pkg::token_t tok;
    logic            last;
  } token_exp_t;

  // directed stimulus row; want is used only when typed is set
  typedef struct packed {
    logic [7:0] b;
    logic       eos;
    logic       typed;
    token_exp_t want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel, penable, pwrite, pready;
  logic [sbt_pkg::APB_ADDR_BITS-1:0] paddr;
  logic [31:0] pwdata, prdata;

  sbt_byte_if  byte_ch ();
  sbt_token_if token_ch ();

  source_byte_tokenizer_unit uut (
    .clk       (clk),
    .rst       (rst),
    .byte_in   (byte_ch),
    .token_out (token_ch),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always #2 clk = ~clk;

  string keyword_names [3] = '{"int", "return", "string"};
  logic [7:0] delim_chars [8] = '{sbt_pkg::CH_NL, sbt_pkg::CH_ASSIGN, sbt_pkg::CH_PLUS,
                                  sbt_pkg::CH_SEMI, sbt_pkg::CH_LPAREN, sbt_pkg::CH_RPAREN,
                                  sbt_pkg::CH_LBRACE, sbt_pkg::CH_RBRACE};
  logic [7:0] symbol_chars [3] = '{sbt_pkg::CH_STAR, sbt_pkg::CH_SLASH, sbt_pkg::CH_COMMA};

  // directed rows: empty source, every single-character token, every word class
  stim_row_t directed_rows [25] = '{
    '{sbt_pkg::CH_SPACE,  1'b1, 1'b1,
      '{'{sbt_pkg::KIND_END,     16'd1, 16'd1,  32'd1,  16'd0}, 1'b1}},
    '{sbt_pkg::CH_NL,     1'b0, 1'b1,
      '{'{sbt_pkg::KIND_NEWLINE, 16'd1, 16'd0,  32'd0,  16'd1}, 1'b1}},
    '{sbt_pkg::CH_ASSIGN, 1'b0, 1'b1,
      '{'{sbt_pkg::KIND_ASSIGN,  16'd2, 16'd0,  32'd1,  16'd1}, 1'b1}},
    '{sbt_pkg::CH_TAB,    1'b0, 1'b0, '0},
    '{sbt_pkg::CH_PLUS,   1'b0, 1'b1,
      '{'{sbt_pkg::KIND_PLUS,    16'd2, 16'd5,  32'd3,  16'd1}, 1'b1}},
    '{sbt_pkg::CH_STAR,   1'b0, 1'b0, '0},
    '{sbt_pkg::CH_LPAREN, 1'b0, 1'b0, '0},
    '{sbt_pkg::CH_SLASH,  1'b0, 1'b0, '0},
    '{sbt_pkg::CH_RPAREN, 1'b0, 1'b0, '0},
    '{sbt_pkg::CH_COMMA,  1'b0, 1'b0, '0},
    '{sbt_pkg::CH_LBRACE, 1'b0, 1'b0, '0},
    '{sbt_pkg::CH_QUOTE,  1'b0, 1'b0, '0},
    '{sbt_pkg::CH_QUOTE,  1'b0, 1'b0, '0},
    '{sbt_pkg::CH_RBRACE, 1'b0, 1'b0, '0},
    '{8'h69,              1'b0, 1'b0, '0},
    '{8'h6E,              1'b0, 1'b0, '0},
    '{8'h74,              1'b0, 1'b0, '0},
    '{sbt_pkg::CH_SEMI,   1'b0, 1'b0, '0},
    '{sbt_pkg::CH_NINE,   1'b0, 1'b0, '0},
    '{8'h78,              1'b0, 1'b0, '0},
    '{sbt_pkg::CH_SPACE,  1'b0, 1'b1,
      '{'{sbt_pkg::KIND_ERROR,   16'd2, 16'd19, 32'd17, 16'd2}, 1'b1}},
    '{8'h37,              1'b0, 1'b0, '0},
    '{sbt_pkg::CH_SPACE,  1'b0, 1'b0, '0},
    '{8'h00,              1'b0, 1'b0, '0},
    '{8'hFF,              1'b1, 1'b0, '0}
  };

  // predictor state and its copy of the registers
  logic [15:0] cfg_first_line;
  logic [4:0]  cfg_tab;
  logic [15:0] line_q, col_q, w_len;
  logic [31:0] pos_q, w_start;
  logic        in_word, digits_only, ends_quote;
  logic [2:0]  kw_hit;
  logic [7:0]  w_first;

  token_exp_t byte_tokens [$];
  token_exp_t expected_tokens [$];

  int mismatch_count = 0;
  int random_items   = 0;
  int send_idle_pct  = 0;
  int sink_stall_pct = 0;
  bit hold_request   = 0;
  int hold_left      = 0;

  function automatic logic [15:0] add_sat16(logic [15:0] a, logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[16] ? 16'hFFFF : s[15:0];
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endfunction

  // word tracking
  function automatic void clear_word();
    in_word     = 1'b0;
    w_start     = '0;
    w_len       = '0;
    digits_only = 1'b0;
    ends_quote  = 1'b0;
    kw_hit      = '1;
    w_first     = '0;
  endfunction

  function automatic void restart_source();
    line_q = cfg_first_line;
    col_q  = '0;
    pos_q  = '0;
    clear_word();
  endfunction

  function automatic void add_token(sbt_pkg::kind_t kind, logic [31:0] off,
                                    logic [15:0] len);
    token_exp_t t;
    t.tok.kind   = kind;
    t.tok.line   = line_q;
    t.tok.column = col_q;
    t.tok.offset = off;
    t.tok.length = len;
    t.last       = 1'b0;
    byte_tokens  = {byte_tokens, t};
  endfunction

  function automatic void append_char(logic [7:0] b);
    for (int k = 0; k < 3; k++) begin
      if (w_len >= keyword_names[k].len() || keyword_names[k][w_len] != b) kw_hit[k] = 1'b0;
    end
    if (!(b >= sbt_pkg::CH_ZERO && b <= sbt_pkg::CH_NINE)) digits_only = 1'b0;
    ends_quote = (b == sbt_pkg::CH_QUOTE);
    w_len = add_sat16(w_len, 16'd1);
  endfunction

  // classify the pending word and emit it
  function automatic void close_word();
    sbt_pkg::kind_t k;
    if (w_len == 1 && w_first == sbt_pkg::CH_STAR) k = sbt_pkg::KIND_STAR;
    else if (w_len == 1 && w_first == sbt_pkg::CH_SLASH) k = sbt_pkg::KIND_SLASH;
    else if (w_len == 1 && w_first == sbt_pkg::CH_COMMA) k = sbt_pkg::KIND_COMMA;
    else if (digits_only) k = sbt_pkg::KIND_NUMBER;
    else if (w_first == sbt_pkg::CH_QUOTE && ends_quote) k = sbt_pkg::KIND_STRING;
    else if (!(w_first >= sbt_pkg::CH_ZERO && w_first <= sbt_pkg::CH_NINE)) begin
      if (kw_hit[0] && w_len == 3) k = sbt_pkg::KIND_KW_INT;
      else if (kw_hit[1] && w_len == 6) k = sbt_pkg::KIND_KW_RET;
      else if (kw_hit[2] && w_len == 6) k = sbt_pkg::KIND_KW_STR;
      else k = sbt_pkg::KIND_IDENT;
    end else k = sbt_pkg::KIND_ERROR;
    add_token(k, w_start, w_len);
    // an error word leaves the column where it was
    if (k != sbt_pkg::KIND_ERROR) col_q = add_sat16(col_q, w_len);
    clear_word();
  endfunction

  // tokens caused by one accepted byte, left in byte_tokens
  function automatic void predict_byte(logic [7:0] b, logic eos);
    logic [31:0] at;
    sbt_pkg::kind_t k;
    logic single, delim;
    byte_tokens.delete();
    at = pos_q;
    k = sbt_pkg::KIND_NEWLINE;
    single = 1'b1;
    case (b)
      sbt_pkg::CH_NL:     k = sbt_pkg::KIND_NEWLINE;
      sbt_pkg::CH_ASSIGN: k = sbt_pkg::KIND_ASSIGN;
      sbt_pkg::CH_PLUS:   k = sbt_pkg::KIND_PLUS;
      sbt_pkg::CH_SEMI:   k = sbt_pkg::KIND_SEMI;
      sbt_pkg::CH_LPAREN: k = sbt_pkg::KIND_LPAREN;
      sbt_pkg::CH_RPAREN: k = sbt_pkg::KIND_RPAREN;
      sbt_pkg::CH_LBRACE: k = sbt_pkg::KIND_LBRACE;
      sbt_pkg::CH_RBRACE: k = sbt_pkg::KIND_RBRACE;
      default:            single = 1'b0;
    endcase
    delim = single || b == sbt_pkg::CH_SPACE || b == sbt_pkg::CH_TAB;
    if (in_word && !delim) begin
      append_char(b);
    end else begin
      if (in_word) close_word();
      if (b == sbt_pkg::CH_SPACE) begin
        col_q = add_sat16(col_q, 16'd1);
      end else if (b == sbt_pkg::CH_TAB) begin
        col_q = add_sat16(col_q, {11'd0, cfg_tab});
      end else if (single && k == sbt_pkg::KIND_NEWLINE) begin
        add_token(k, at, 16'd1);
        line_q = add_sat16(line_q, 16'd1);
        col_q  = '0;
      end else if (single) begin
        add_token(k, at, 16'd1);
        col_q = add_sat16(col_q, 16'd1);
      end else begin
        in_word     = 1'b1;
        w_start     = at;
        w_len       = '0;
        digits_only = 1'b1;
        ends_quote  = 1'b0;
        kw_hit      = '1;
        w_first     = b;
        append_char(b);
      end
    end
    pos_q = (at == '1) ? at : at + 32'd1;
    // end of source: flush, end marker, counters back to the start
    if (eos) begin
      if (in_word) close_word();
      add_token(sbt_pkg::KIND_END, pos_q, 16'd0);
      restart_source();
    end
    if (byte_tokens.size() > 0) byte_tokens[byte_tokens.size() - 1].last = 1'b1;
  endfunction

  // offer one byte item, wait for it to be taken, record what it should produce
  task automatic offer_byte(logic [7:0] b, logic eos, logic typed, token_exp_t want);
    if ($urandom_range(99) < send_idle_pct) begin
      byte_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    byte_ch.valid         <= 1'b1;
    byte_ch.source_byte   <= b;
    byte_ch.end_of_source <= eos;
    do @(posedge clk); while (!byte_ch.ready);
    predict_byte(b, eos);
    if (typed) expected_tokens = {expected_tokens, want};
    else expected_tokens = {expected_tokens, byte_tokens};
  endtask

  // stop sending and wait until every expected token has come out
  task automatic drain();
    byte_ch.valid <= 1'b0;
    while (expected_tokens.size() != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  // APB write, then read back and compare
  task automatic set_register(logic idx, logic [31:0] value);
    logic [31:0] held;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (idx == sbt_pkg::REG_FIRST_LINE) begin
      cfg_first_line = value[15:0];
      // an untouched source picks up the new first line at once
      if (pos_q == 0 && !in_word) line_q = cfg_first_line;
      held = {16'd0, value[15:0]};
    end else begin
      cfg_tab = value[4:0];
      held = {27'd0, value[4:0]};
    end
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    check_field("prdata", held, prdata);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // one random piece of source text: mostly well formed, some broken, some noise
  task automatic offer_random_piece();
    logic [7:0] chunk [$];
    string kw;
    int pick, n;
    pick = $urandom_range(99);
    if (pick < 20) begin
      kw = keyword_names[$urandom_range(2)];
      for (int i = 0; i < kw.len(); i++) chunk = {chunk, 8'(kw[i])};
      case ($urandom_range(3))
        1: void'(chunk.pop_back());
        2: chunk = {chunk, 8'(8'h61 + $urandom_range(25))};
        3: chunk[chunk.size() - 1] = 8'(8'h61 + $urandom_range(25));
        default: ;
      endcase
    end else if (pick < 35) begin
      chunk = {chunk, (($urandom_range(5) == 0) ? 8'h5F : 8'(8'h61 + $urandom_range(25)))};
      n = $urandom_range(5);
      repeat (n) chunk = {chunk, ($urandom_range(1) ? 8'(8'h61 + $urandom_range(25))
                                                    : 8'(sbt_pkg::CH_ZERO + $urandom_range(9)))};
    end else if (pick < 48) begin
      n = $urandom_range(5, 1);
      repeat (n) chunk = {chunk, 8'(sbt_pkg::CH_ZERO + $urandom_range(9))};
    end else if (pick < 56) begin
      chunk = {chunk, sbt_pkg::CH_QUOTE};
      n = $urandom_range(4);
      repeat (n) chunk = {chunk, 8'(8'h61 + $urandom_range(25))};
      // a quarter are left unterminated
      if ($urandom_range(3) != 0) chunk = {chunk, sbt_pkg::CH_QUOTE};
    end else if (pick < 66) begin
      chunk = {chunk, symbol_chars[$urandom_range(2)]};
    end else if (pick < 76) begin
      chunk = {chunk, 8'(sbt_pkg::CH_ZERO + $urandom_range(9))};
      n = $urandom_range(3, 1);
      repeat (n) chunk = {chunk, 8'(8'h61 + $urandom_range(25))};
    end else if (pick < 90) begin
      chunk = {chunk, delim_chars[$urandom_range(7)]};
    end else begin
      n = $urandom_range(3, 1);
      repeat (n) chunk = {chunk, 8'($urandom_range(255))};
    end
    // separator after nine pieces in ten
    pick = $urandom_range(99);
    if (pick < 50) chunk = {chunk, sbt_pkg::CH_SPACE};
    else if (pick < 70) chunk = {chunk, sbt_pkg::CH_TAB};
    else if (pick < 90) chunk = {chunk, delim_chars[$urandom_range(7)]};
    foreach (chunk[i]) begin
      offer_byte(chunk[i], $urandom_range(29) == 0, 1'b0, '0);
      random_items++;
    end
  endtask

  // token checker
  always @(posedge clk) begin
    if (!rst && token_ch.valid && token_ch.ready) begin
      if (expected_tokens.size() == 0) begin
        $error("token with nothing expected: kind %0d offset %0d",
               token_ch.token_kind, token_ch.token_offset);
        mismatch_count++;
      end else begin
        token_exp_t want;
        want = expected_tokens.pop_front();
        check_field("token_kind",   want.tok.kind,   token_ch.token_kind);
        check_field("token_line",   want.tok.line,   token_ch.token_line);
        check_field("token_column", want.tok.column, token_ch.token_column);
        check_field("token_offset", want.tok.offset, token_ch.token_offset);
        check_field("token_length", want.tok.length, token_ch.token_length);
        check_field("last_in_run",  want.last,       token_ch.last_in_run);
      end
    end
  end

  // token receiver: random stalls, or a long hold-off when asked
  always @(posedge clk) begin
    if (hold_request) begin
      hold_request = 0;
      hold_left    = LONG_HOLD;
    end
    if (hold_left != 0) begin
      hold_left--;
      token_ch.ready <= 1'b0;
    end else begin
      token_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // run limit
  initial begin
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // main sequence
  initial begin
    byte_ch.valid         = 1'b0;
    byte_ch.source_byte   = '0;
    byte_ch.end_of_source = 1'b0;
    token_ch.ready        = 1'b0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    cfg_first_line = sbt_pkg::FIRST_LINE_RST;
    cfg_tab        = sbt_pkg::TAB_WIDTH_RST;
    restart_source();

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part at the reset settings
    set_register(sbt_pkg::REG_FIRST_LINE, 32'd1);
    set_register(sbt_pkg::REG_TAB_WIDTH, 32'd4);
    foreach (directed_rows[i])
      offer_byte(directed_rows[i].b, directed_rows[i].eos, directed_rows[i].typed,
                 directed_rows[i].want);
    drain();

    // fresh source: first line loads at once
    set_register(sbt_pkg::REG_FIRST_LINE, 32'd7);
    set_register(sbt_pkg::REG_TAB_WIDTH, 32'd2);

    // receiver holds off while bytes keep coming, so the queue fills
    hold_request = 1;
    repeat (30) offer_byte(delim_chars[$urandom_range(7)], 1'b0, 1'b0, '0);
    drain();

    // random phases, each with its own settings and flow control
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = PHASE_SEND_IDLE[ph];
      sink_stall_pct = PHASE_SINK_STALL[ph];
      set_register(sbt_pkg::REG_FIRST_LINE, {16'd0, PHASE_FIRST_LINE[ph]});
      set_register(sbt_pkg::REG_TAB_WIDTH, {27'd0, PHASE_TAB[ph]});
      while (random_items < PHASE_ITEMS * (ph + 1)) offer_random_piece();
      drain();
    end

    // close the last source
    send_idle_pct  = 0;
    sink_stall_pct = 0;
    offer_byte(sbt_pkg::CH_NL, 1'b1, 1'b0, '0);
    drain();

    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/sbt_pkg.sv
hw/rtl/sbt_if.sv
hw/rtl/sbt_front.sv
hw/rtl/sbt_queue.sv
hw/rtl/sbt_back.sv
hw/rtl/source_byte_tokenizer_unit.sv
hw/rtl/sbt_checker.sv
bench/testbench.sv
